[hdl/uaf_pkg.sv]
// ----------------------------------------------------------------------------
// uaf_pkg
// Types, codes and helper functions shared by the anisotropy field block.
// ----------------------------------------------------------------------------
package uaf_pkg;

  // 1.0 in Q8.24
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_K_FIRST     = 3'd0,
    CFG_K_SECOND    = 3'd1,
    CFG_INV_MOMENT  = 3'd2,
    CFG_FIELD_SCALE = 3'd3,
    CFG_AXIS_X      = 3'd4,
    CFG_AXIS_Y      = 3'd5,
    CFG_AXIS_Z      = 3'd6,
    CFG_INV_VOLUME  = 3'd7
  } cfg_idx_e;

  // Right shift applied to a product by the shared multiplier
  typedef enum logic [1:0] {
    SH_0,
    SH_23,
    SH_24
  } shift_e;

  // Sequencer states, one per step of the per-item schedule
  typedef enum logic [4:0] {
    S_IDLE,
    S_MX,
    S_MY,
    S_MZ,
    S_D,
    S_D2,
    S_U,
    S_K2A,
    S_K2B,
    S_BR,
    S_G,
    S_H,
    S_FX,
    S_FY,
    S_FZ,
    S_E,
    S_SUM,
    S_MAG,
    S_DLO,
    S_DHI,
    S_Q,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
    logic               occupied;
    logic               sweep_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic signed [31:0] cell_energy;
    logic signed [47:0] energy_density;
    logic               density_valid;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] k_first;
    logic signed [31:0] k_second;
    logic        [31:0] inv_moment;
    logic        [31:0] field_scale;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic        [31:0] inv_volume;
  } cfg_t;

  // One operation for the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
    shift_e             sh;
  } op_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/uaf_if.sv]
// ----------------------------------------------------------------------------
// uaf_if
// Valid/ready channels for spin items in and field items out.
// ----------------------------------------------------------------------------
interface uaf_in_if import uaf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface uaf_out_if import uaf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[hdl/uaf_cfg.sv]
// ----------------------------------------------------------------------------
// uaf_cfg
// Configuration register file, written by index, read as one struct.
// ----------------------------------------------------------------------------
module uaf_cfg import uaf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [2:0]  idx_i,
  input  logic [31:0] data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_first     <= '0;
      cfg_q.k_second    <= '0;
      cfg_q.inv_moment  <= ONE_Q24;
      cfg_q.field_scale <= ONE_Q24;
      cfg_q.axis_x      <= ONE_Q24;
      cfg_q.axis_y      <= '0;
      cfg_q.axis_z      <= '0;
      cfg_q.inv_volume  <= '0;
    end else if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_K_FIRST:     cfg_q.k_first     <= data_i;
        CFG_K_SECOND:    cfg_q.k_second    <= data_i;
        CFG_INV_MOMENT:  cfg_q.inv_moment  <= data_i;
        CFG_FIELD_SCALE: cfg_q.field_scale <= data_i;
        CFG_AXIS_X:      cfg_q.axis_x      <= data_i;
        CFG_AXIS_Y:      cfg_q.axis_y      <= data_i;
        CFG_AXIS_Z:      cfg_q.axis_z      <= data_i;
        CFG_INV_VOLUME:  cfg_q.inv_volume  <= data_i;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/uaf_mulq.sv]
// ----------------------------------------------------------------------------
// uaf_mulq
// Shared 33x33 signed multiplier with floor shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module uaf_mulq import uaf_pkg::*; (
  input  op_t                op_i,
  output logic signed [65:0] shifted_o,
  output logic signed [31:0] res_o
);

  logic signed [65:0] prod;

  // Exact product; arithmetic shift floors toward minus infinity
  assign prod = 66'(op_i.a) * 66'(op_i.b);

  // Select the shift; the Q8.24 shift covers every other code
  always_comb begin
    unique case (op_i.sh)
      SH_0:    shifted_o = prod;
      SH_23:   shifted_o = prod >>> 23;
      default: shifted_o = prod >>> 24;
    endcase
  end

  assign res_o = sat32(shifted_o);

endmodule

[hdl/uniaxial_anisotropy_field.sv]
// ----------------------------------------------------------------------------
// uniaxial_anisotropy_field
// Uniaxial K1/K2 anisotropy field and energy per spin, with a sweep energy
// sum scaled by the inverse volume on the last item of each sweep.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    moment_x/y/z, occupied, sweep_end
//   out_o    out  valid/ready    field_x/y/z, cell_energy, energy_density,
//                                density_valid
//   cfg      in   cfg_we_i       cfg_idx_i (0..7), cfg_data_i (32 bits)
//
// One multiplier is stepped through thirteen products per occupied item, and
// a sweep end adds two more products for the density. An empty cell goes
// straight to its result, or through the density steps on a sweep end.
// Reset clears the sequencer, the output valid and the energy sum.
// The input is held off until the item is finished; a stalled output only
// holds the next result back at its last step.
// ----------------------------------------------------------------------------
module uniaxial_anisotropy_field import uaf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  uaf_in_if.sink       in_i,
  uaf_out_if.source    out_o
);

  cfg_t               cfg;
  state_e             state_q, state_d;
  op_t                op;
  logic signed [65:0] shifted;
  logic signed [31:0] res;
  logic               out_load;

  // Control state
  logic               out_valid_q;
  logic signed [63:0] sum_q;

  // Working registers
  in_item_t           in_q;
  out_item_t          out_q;
  logic signed [41:0] acc_q;
  logic signed [31:0] d_q, t_q, u_q, be_q;
  logic signed [31:0] fx_q, fy_q, fz_q, e_q;
  logic        [63:0] mag_q, phi_q, q_q;
  logic        [31:0] plo_hi_q;
  logic               neg_q, lo_nz_q;

  logic signed [64:0] sum_ext;
  logic signed [63:0] sum_sat;
  logic signed [47:0] dens;

  uaf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  uaf_mulq u_mulq (
    .op_i      (op),
    .shifted_o (shifted),
    .res_o     (res)
  );

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Choose the operands for the shared multiplier and advance
  always_comb begin
    state_d  = state_q;
    op.a     = '0;
    op.b     = '0;
    op.sh    = SH_24;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.item.occupied) begin
            state_d = S_MX;
          end else if (in_i.item.sweep_end) begin
            state_d = S_MAG;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_MX: begin
        op.a    = 33'(in_q.moment_x);
        op.b    = 33'(cfg.axis_x);
        state_d = S_MY;
      end
      S_MY: begin
        op.a    = 33'(in_q.moment_y);
        op.b    = 33'(cfg.axis_y);
        state_d = S_MZ;
      end
      S_MZ: begin
        op.a    = 33'(in_q.moment_z);
        op.b    = 33'(cfg.axis_z);
        state_d = S_D;
      end
      S_D: begin
        op.a    = 33'(sat32(66'(acc_q)));
        op.b    = $signed({1'b0, cfg.inv_moment});
        state_d = S_D2;
      end
      S_D2: begin
        op.a    = 33'(d_q);
        op.b    = 33'(d_q);
        state_d = S_U;
      end
      S_U: begin
        state_d = S_K2A;
      end
      S_K2A: begin
        op.a    = 33'(cfg.k_second);
        op.b    = 33'(u_q);
        op.sh   = SH_23;
        state_d = S_K2B;
      end
      S_K2B: begin
        op.a    = 33'(cfg.k_second);
        op.b    = 33'(u_q);
        state_d = S_BR;
      end
      S_BR: begin
        state_d = S_G;
      end
      S_G: begin
        op.a    = 33'(d_q);
        op.b    = 33'(t_q);
        state_d = S_H;
      end
      S_H: begin
        op.a    = $signed({1'b0, cfg.field_scale});
        op.b    = 33'(t_q);
        state_d = S_FX;
      end
      S_FX: begin
        op.a    = 33'(t_q);
        op.b    = 33'(cfg.axis_x);
        state_d = S_FY;
      end
      S_FY: begin
        op.a    = 33'(t_q);
        op.b    = 33'(cfg.axis_y);
        state_d = S_FZ;
      end
      S_FZ: begin
        op.a    = 33'(t_q);
        op.b    = 33'(cfg.axis_z);
        state_d = S_E;
      end
      S_E: begin
        op.a    = 33'(be_q);
        op.b    = 33'(u_q);
        state_d = S_SUM;
      end
      S_SUM: begin
        state_d = in_q.sweep_end ? S_MAG : S_OUT;
      end
      S_MAG: begin
        state_d = S_DLO;
      end
      S_DLO: begin
        op.a    = $signed({1'b0, mag_q[31:0]});
        op.b    = $signed({1'b0, cfg.inv_volume});
        op.sh   = SH_0;
        state_d = S_DHI;
      end
      S_DHI: begin
        op.a    = $signed({1'b0, mag_q[63:32]});
        op.b    = $signed({1'b0, cfg.inv_volume});
        op.sh   = SH_0;
        state_d = S_Q;
      end
      S_Q: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Saturating add of the cell energy into the sweep sum
  assign sum_ext = 65'(sum_q) + 65'(e_q);
  always_comb begin
    if (sum_ext[64] != sum_ext[63]) begin
      sum_sat = sum_ext[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      sum_sat = sum_ext[63:0];
    end
  end

  // Clamp the scaled sum to 48 bits and restore its sign
  always_comb begin
    if (neg_q) begin
      if (q_q > 64'h0000_8000_0000_0000) begin
        dens = 48'sh8000_0000_0000;
      end else begin
        dens = -$signed(q_q[47:0]);
      end
    end else if (q_q > 64'h0000_7FFF_FFFF_FFFF) begin
      dens = 48'sh7FFF_FFFF_FFFF;
    end else begin
      dens = $signed(q_q[47:0]);
    end
  end

  // Sweep sum and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_SUM) begin
        sum_q <= sum_sat;
      end else if (out_load && in_q.sweep_end) begin
        sum_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture step results
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.item;
    end
    unique case (state_q)
      S_MX:  acc_q <= $signed(shifted[41:0]);
      S_MY:  acc_q <= acc_q + $signed(shifted[41:0]);
      S_MZ:  acc_q <= acc_q + $signed(shifted[41:0]);
      S_D:   d_q   <= res;
      S_D2:  t_q   <= res;
      S_U:   u_q   <= sat32(66'($signed({2'b00, ONE_Q24}) - 34'(t_q)));
      S_K2A: t_q   <= res;
      S_K2B: be_q  <= res;
      S_BR: begin
        t_q  <= sat32(66'(33'(cfg.k_first) + 33'(t_q)));
        be_q <= sat32(66'(33'(cfg.k_first) + 33'(be_q)));
      end
      S_G:   t_q   <= res;
      S_H:   t_q   <= res;
      S_FX:  fx_q  <= res;
      S_FY:  fy_q  <= res;
      S_FZ:  fz_q  <= res;
      S_E:   e_q   <= res;
      S_MAG: begin
        neg_q <= sum_q[63];
        mag_q <= sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
      end
      S_DLO: begin
        plo_hi_q <= shifted[63:32];
        lo_nz_q  <= |shifted[31:0];
      end
      S_DHI: phi_q <= shifted[63:0];
      S_Q:   q_q   <= phi_q + {32'd0, plo_hi_q} + {63'd0, neg_q & lo_nz_q};
      default: begin
      end
    endcase
    if (out_load) begin
      out_q.field_x        <= in_q.occupied ? fx_q : '0;
      out_q.field_y        <= in_q.occupied ? fy_q : '0;
      out_q.field_z        <= in_q.occupied ? fz_q : '0;
      out_q.cell_energy    <= in_q.occupied ? e_q : '0;
      out_q.energy_density <= in_q.sweep_end ? dens : '0;
      out_q.density_valid  <= in_q.sweep_end;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the uniaxial anisotropy field block. Spin items go
// in over the valid/ready channel. Each accepted item is run through a local
// fixed-point predictor of the field, the cell energy and the sweep energy
// density, and each result is checked field by field against the oldest
// prediction. Directed corner items come first. Random sweeps then run under
// several register settings and idling mixes on both channels.
// ----------------------------------------------------------------------------
module tb;
  import uaf_pkg::*;

  localparam int     STALL_LIMIT  = 1000;
  localparam int     DRAIN_CYCLES = 30;
  localparam longint Q24_ONE      = 64'sd16777216;
  localparam longint S32_MAX      = 64'sd2147483647;
  localparam longint S32_MIN      = -64'sd2147483648;
  localparam longint D48_MAX      = 64'sd140737488355327;
  localparam longint D48_MIN      = -64'sd140737488355328;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [31:0] cfg_data;

  uaf_in_if  in_ch ();
  uaf_out_if out_ch ();

  uniaxial_anisotropy_field dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Predictor state: register copy, sweep energy sum and queue of predictions
  cfg_t      model_cfg;
  longint    model_energy_sum;
  out_item_t awaited_fields[$];

  int mismatches;
  int stall_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp32(longint x);
    if (x > S32_MAX) begin
      return S32_MAX;
    end
    if (x < S32_MIN) begin
      return S32_MIN;
    end
    return x;
  endfunction

  // Exact product, floor shift, clamp to Q8.24
  function automatic longint mul_floor(longint a, longint b, int sh);
    return clamp32((a * b) >>> sh);
  endfunction

  function automatic out_item_t predict_field(in_item_t it);
    out_item_t               r;
    longint                  mx, my, mz, ax, ay, az, k1, k2, im, fs;
    longint                  dot, d, d2, u, k2u2, k2u, bf, be, g, h, e;
    longint                  fx, fy, fz;
    logic signed [64:0]      acc;
    logic signed [127:0]     sum_w, inv_w, wide;
    r = '0;
    if (it.occupied) begin
      mx  = longint'($signed(it.moment_x));
      my  = longint'($signed(it.moment_y));
      mz  = longint'($signed(it.moment_z));
      ax  = longint'($signed(model_cfg.axis_x));
      ay  = longint'($signed(model_cfg.axis_y));
      az  = longint'($signed(model_cfg.axis_z));
      k1  = longint'($signed(model_cfg.k_first));
      k2  = longint'($signed(model_cfg.k_second));
      im  = longint'(model_cfg.inv_moment);
      fs  = longint'(model_cfg.field_scale);
      dot = clamp32(((mx * ax) >>> 24) + ((my * ay) >>> 24) + ((mz * az) >>> 24));
      d    = mul_floor(dot, im, 24);
      d2   = mul_floor(d, d, 24);
      u    = clamp32(Q24_ONE - d2);
      k2u2 = mul_floor(k2, u, 23);
      k2u  = mul_floor(k2, u, 24);
      bf   = clamp32(k1 + k2u2);
      be   = clamp32(k1 + k2u);
      g    = mul_floor(d, bf, 24);
      h    = mul_floor(fs, g, 24);
      fx   = mul_floor(h, ax, 24);
      fy   = mul_floor(h, ay, 24);
      fz   = mul_floor(h, az, 24);
      e    = mul_floor(be, u, 24);
      r.field_x     = fx[31:0];
      r.field_y     = fy[31:0];
      r.field_z     = fz[31:0];
      r.cell_energy = e[31:0];
      // Accumulate with saturation at the 64-bit limits
      acc = model_energy_sum;
      acc = acc + e;
      if (acc[64] != acc[63]) begin
        model_energy_sum = acc[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        model_energy_sum = acc[63:0];
      end
    end
    if (it.sweep_end) begin
      sum_w = model_energy_sum;
      inv_w = {96'd0, model_cfg.inv_volume};
      wide  = (sum_w * inv_w) >>> 32;
      if (wide > D48_MAX) begin
        wide = D48_MAX;
      end else if (wide < D48_MIN) begin
        wide = D48_MIN;
      end
      r.energy_density = wide[47:0];
      r.density_valid  = 1'b1;
      model_energy_sum = 0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: predict on input acceptance, check on output acceptance
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      awaited_fields.push_back(predict_field(in_ch.item));
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.item;
      if (awaited_fields.size() == 0) begin
        report_mismatch("unexpected result field_x", $signed(got.field_x), 0);
      end else begin
        want = awaited_fields.pop_front();
        if (got.field_x !== want.field_x)
          report_mismatch("field_x", $signed(got.field_x), $signed(want.field_x));
        if (got.field_y !== want.field_y)
          report_mismatch("field_y", $signed(got.field_y), $signed(want.field_y));
        if (got.field_z !== want.field_z)
          report_mismatch("field_z", $signed(got.field_z), $signed(want.field_z));
        if (got.cell_energy !== want.cell_energy)
          report_mismatch("cell_energy", $signed(got.cell_energy),
                          $signed(want.cell_energy));
        if (got.energy_density !== want.energy_density)
          report_mismatch("energy_density", $signed(got.energy_density),
                          $signed(want.energy_density));
        if (got.density_valid !== want.density_valid)
          report_mismatch("density_valid", got.density_valid, want.density_valid);
      end
    end
  end

  // Random back-pressure on the result channel
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no item moving on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    @(negedge clk);
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("mismatch: no item moved for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic in_item_t make_item(longint x, longint y, longint z, bit occ,
                                         bit last);
    in_item_t it;
    it.moment_x  = x[31:0];
    it.moment_y  = y[31:0];
    it.moment_z  = z[31:0];
    it.occupied  = occ;
    it.sweep_end = last;
    return it;
  endfunction

  // Present one item, with a random idle gap first; return at its acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited_fields.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_K_FIRST:     model_cfg.k_first     = data;
      CFG_K_SECOND:    model_cfg.k_second    = data;
      CFG_INV_MOMENT:  model_cfg.inv_moment  = data;
      CFG_FIELD_SCALE: model_cfg.field_scale = data;
      CFG_AXIS_X:      model_cfg.axis_x      = data;
      CFG_AXIS_Y:      model_cfg.axis_y      = data;
      CFG_AXIS_Z:      model_cfg.axis_z      = data;
      CFG_INV_VOLUME:  model_cfg.inv_volume  = data;
      default:         ;
    endcase
    @(posedge clk);
  endtask

  // Load all registers once the block is idle
  task automatic apply_config(cfg_t c);
    wait_drained();
    write_reg(CFG_K_FIRST, c.k_first);
    write_reg(CFG_K_SECOND, c.k_second);
    write_reg(CFG_INV_MOMENT, c.inv_moment);
    write_reg(CFG_FIELD_SCALE, c.field_scale);
    write_reg(CFG_AXIS_X, c.axis_x);
    write_reg(CFG_AXIS_Y, c.axis_y);
    write_reg(CFG_AXIS_Z, c.axis_z);
    write_reg(CFG_INV_VOLUME, c.inv_volume);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------
  // Mostly within +-1.5, some full range, some extremes
  function automatic longint rand_moment();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return longint'($urandom_range(50331648)) - 25165824;
    end
    if (r < 90) begin
      return longint'($signed($urandom));
    end
    case ($urandom_range(3))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return Q24_ONE;
      default: return -Q24_ONE;
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff();
    longint v;
    if ($urandom_range(99) < 80) begin
      v = longint'($urandom_range(67108864)) - 33554432;
    end else begin
      v = longint'($signed($urandom));
    end
    return v[31:0];
  endfunction

  function automatic cfg_t random_config();
    cfg_t   c;
    longint s;
    c.k_first     = rand_coeff();
    c.k_second    = rand_coeff();
    c.inv_moment  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(33554432, 8388608);
    c.field_scale = $urandom_range(67108864);
    c.inv_volume  = $urandom;
    if ($urandom_range(1)) begin
      // Unit axis along x, y or z with a random sign
      s = $urandom_range(1) ? Q24_ONE : -Q24_ONE;
      c.axis_x = '0;
      c.axis_y = '0;
      c.axis_z = '0;
      case ($urandom_range(2))
        0:       c.axis_x = s[31:0];
        1:       c.axis_y = s[31:0];
        default: c.axis_z = s[31:0];
      endcase
    end else begin
      s = longint'($urandom_range(33554432)) - Q24_ONE;
      c.axis_x = s[31:0];
      s = longint'($urandom_range(33554432)) - Q24_ONE;
      c.axis_y = s[31:0];
      s = longint'($urandom_range(33554432)) - Q24_ONE;
      c.axis_z = s[31:0];
    end
    return c;
  endfunction

  // Random sweeps of 1..16 cells; optionally drain once part-way through
  task automatic run_sweeps(int n_items, int pause_at);
    int left_in_sweep;
    int i;
    left_in_sweep = 0;
    for (i = 0; i < n_items; i++) begin
      if (left_in_sweep == 0) begin
        left_in_sweep = $urandom_range(16, 1);
      end
      left_in_sweep--;
      send_item(make_item(rand_moment(), rand_moment(), rand_moment(),
                          $urandom_range(99) < 85, left_in_sweep == 0));
      if (i == pause_at) begin
        wait_drained();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Registers at their reset values: zero K, unit x axis, zero inverse volume
  task automatic test_reset_config();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(make_item(Q24_ONE, 0, 0, 1'b1, 1'b0));
    send_item(make_item(S32_MAX, S32_MIN, 0, 1'b1, 1'b0));
    send_item(make_item(S32_MIN, S32_MAX, S32_MAX, 1'b0, 1'b0));
    send_item(make_item(Q24_ONE / 2, 0, 0, 1'b1, 1'b1));
  endtask

  // Tilted axis, positive K1, negative K2: along, against and across the axis
  task automatic test_directed_cells();
    cfg_t c;
    c.k_first     = 32'd12582912;
    c.k_second    = -32'sd6710886;
    c.inv_moment  = ONE_Q24;
    c.field_scale = 32'd33554432;
    c.axis_x      = 32'd10066330;
    c.axis_y      = '0;
    c.axis_z      = 32'd13421773;
    c.inv_volume  = 32'h1000_0000;
    apply_config(c);
    send_item(make_item(10066330, 0, 13421773, 1'b1, 1'b0));
    send_item(make_item(-10066330, 0, -13421773, 1'b1, 1'b0));
    send_item(make_item(0, Q24_ONE, 0, 1'b1, 1'b0));
    send_item(make_item(5033165, 0, 6710886, 1'b1, 1'b0));
    send_item(make_item(S32_MAX, S32_MAX, S32_MAX, 1'b1, 1'b0));
    send_item(make_item(S32_MIN, S32_MIN, S32_MIN, 1'b1, 1'b0));
    send_item(make_item(0, 0, 0, 1'b1, 1'b0));
    send_item(make_item(S32_MAX, S32_MAX, S32_MAX, 1'b0, 1'b0));
    send_item(make_item(Q24_ONE, Q24_ONE, Q24_ONE, 1'b1, 1'b1));
    // Empty last cell straight after a cleared sum
    send_item(make_item(0, 0, 0, 1'b0, 1'b1));
    send_item(make_item(0, 0, Q24_ONE, 1'b1, 1'b0));
    send_item(make_item(0, -Q24_ONE, 0, 1'b1, 1'b1));
  endtask

  // Registers at their limits, where many intermediates saturate
  task automatic test_register_extremes();
    cfg_t c;
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    c.k_first     = 32'h7FFF_FFFF;
    c.k_second    = 32'h7FFF_FFFF;
    c.inv_moment  = 32'hFFFF_FFFF;
    c.field_scale = 32'hFFFF_FFFF;
    c.axis_x      = 32'h7FFF_FFFF;
    c.axis_y      = 32'h7FFF_FFFF;
    c.axis_z      = 32'h7FFF_FFFF;
    c.inv_volume  = 32'hFFFF_FFFF;
    apply_config(c);
    run_sweeps(30, -1);
    c.k_first     = 32'h8000_0000;
    c.k_second    = 32'h8000_0000;
    c.inv_moment  = '0;
    c.field_scale = '0;
    c.axis_x      = 32'h8000_0000;
    c.axis_y      = 32'h8000_0000;
    c.axis_z      = 32'h8000_0000;
    c.inv_volume  = '0;
    apply_config(c);
    run_sweeps(30, -1);
    // Opposing constants with the axis at its negative limit
    c.k_first     = 32'h8000_0000;
    c.k_second    = 32'h7FFF_FFFF;
    c.inv_moment  = 32'hFFFF_FFFF;
    c.field_scale = ONE_Q24;
    c.inv_volume  = 32'hFFFF_FFFF;
    apply_config(c);
    run_sweeps(30, -1);
  endtask

  // Random sweeps under each idling mix, one with a full drain part-way
  task automatic test_idling_phases();
    int idle_tab[4];
    int stall_tab[4];
    int p;
    idle_tab  = '{0, 52, 0, 23};
    stall_tab = '{0, 0, 52, 23};
    for (p = 0; p < 4; p++) begin
      apply_config(random_config());
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      run_sweeps(150, (p == 1) ? 70 : -1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_K_FIRST;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.item       = '0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    stall_cycles     = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    model_energy_sum = 0;
    model_cfg.k_first     = '0;
    model_cfg.k_second    = '0;
    model_cfg.inv_moment  = ONE_Q24;
    model_cfg.field_scale = ONE_Q24;
    model_cfg.axis_x      = ONE_Q24;
    model_cfg.axis_y      = '0;
    model_cfg.axis_z      = '0;
    model_cfg.inv_volume  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_directed_cells();
    test_register_extremes();
    test_idling_phases();

    // Let the last results land, then allow for stray output
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
